[sv/radar_target_frame_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Radar target frame decoder assertion macros
// Concurrent assertion wrappers, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef RADAR_TARGET_FRAME_DECODER_ASSERT_SVH
`define RADAR_TARGET_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define RTFD_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("rtfd assertion failed");

// The condition must never be seen at a rising edge outside reset.
`define RTFD_NEVER(lbl, clk_i, rst_ni, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
		else $error("rtfd forbidden condition seen");

`else

`define RTFD_ASSERT(lbl, clk_i, rst_ni, prop)
`define RTFD_NEVER(lbl, clk_i, rst_ni, cond)

`endif

`endif

[sv/rtfd_pkg.sv]
// ----------------------------------------------------------------------------
// Radar target frame decoder package
// Frame layout constants and the decode helpers shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtfd_pkg;

	// Default number of target slots in one frame.
	localparam int unsigned TARGET_SLOTS_DEF = 3;

	// Frame layout: header, slots of four little-endian words, two tail bytes.
	localparam int unsigned HDR_LEN  = 4;
	localparam int unsigned SLOT_LEN = 8;

	localparam logic [7:0] SYNC_B0 = 8'hAA;
	localparam logic [7:0] SYNC_B1 = 8'hFF;
	localparam logic [7:0] SYNC_B2 = 8'h03;
	localparam logic [7:0] SYNC_B3 = 8'h00;
	localparam logic [7:0] TAIL_B0 = 8'h55;
	localparam logic [7:0] TAIL_B1 = 8'hCC;

	// Widths of the result fields.
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned FCOUNT_W = 32;
	localparam int unsigned OUT_DW   = 4 * WORD_W + FCOUNT_W;
	localparam int unsigned OUT_UW   = 3;

	// Expected header byte at a given header position.
	function automatic logic [7:0] sync_byte(input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0:    b = SYNC_B0;
			2'd1:    b = SYNC_B1;
			2'd2:    b = SYNC_B2;
			default: b = SYNC_B3;
		endcase
		return b;
	endfunction

	// Sign-magnitude word to two's complement: bit 15 set means positive.
	function automatic logic signed [WORD_W-1:0] sm_decode(input logic [WORD_W-1:0] raw);
		logic signed [WORD_W-1:0] v;
		if (raw[WORD_W-1]) begin
			v = signed'({1'b0, raw[WORD_W-2:0]});
		end else begin
			v = signed'(-raw);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[sv/radar_target_frame_decoder.sv]
// ----------------------------------------------------------------------------
// Radar target frame decoder
// Finds fixed-length frames in a received byte stream, checks the tail and
// emits one decoded result per target slot.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Width        Contents
// s_axis    in   tdata 8      one received byte
// m_axis    out  tdata 96     x, y, speed, resolution, frame number
//                tuser 3      target index, target valid; tlast on last slot
//
// One byte is taken every cycle. A complete good frame is copied into a slot
// bank in the cycle of its last byte; the output register then drains the bank
// at one result per cycle while m_axis is ready, TARGET_SLOTS results in all.
// The last tail byte of the following frame is held off only while results of
// the previous frame remain in the bank. Reset is asynchronous and returns the
// block to header search with the frame count at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radar_target_frame_decoder_assert.svh"

module radar_target_frame_decoder
	import rtfd_pkg::*;
#(
	parameter int unsigned TARGET_SLOTS = TARGET_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // [7:0] rx_byte
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// [15:0] x_mm, [31:16] y_mm, [47:32] radial_speed, [63:48] range_res,
	// [95:64] frame_number
	output logic [OUT_DW-1:0]      m_axis_tdata,
	output logic [OUT_UW-1:0]      m_axis_tuser,  // [1:0] target_index, [2] target_valid
	output logic                   m_axis_tlast   // last_of_frame
);

	localparam int unsigned PAY_BYTES = TARGET_SLOTS * SLOT_LEN;
	localparam int unsigned SREG_LEN  = PAY_BYTES + 1;
	localparam int unsigned FRAME_LEN = HDR_LEN + PAY_BYTES + 2;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);
	localparam int unsigned CNT_W     = $clog2(TARGET_SLOTS + 1);
	localparam int unsigned IDX_W     = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;

	logic [POS_W-1:0]    pos_q;
	logic [7:0]          sreg_q [SREG_LEN];
	logic [7:0]          bank_q [PAY_BYTES];
	logic [CNT_W-1:0]    bank_left_q;
	logic [IDX_W-1:0]    slot_idx_q;
	logic [FCOUNT_W-1:0] frame_cnt_q;
	logic [FCOUNT_W-1:0] bank_fnum_q;

	logic                  out_valid_q;
	logic [OUT_DW-1:0]     out_data_q;
	logic [OUT_UW-1:0]     out_user_q;
	logic                  out_last_q;

	logic                  in_xfer;
	logic                  in_header;
	logic                  at_last_byte;
	logic                  frame_good;
	logic                  bank_pop;
	logic                  out_free;
	logic [WORD_W-1:0]     raw_x, raw_y, raw_s, raw_r;
	logic                  slot_nonzero;
	logic [IDX_W+1:0]      idx_ext;

	// Input side: the last tail byte is held off while the bank is still draining.
	assign in_header     = pos_q < POS_W'(HDR_LEN);
	assign at_last_byte  = pos_q == POS_W'(FRAME_LEN - 1);
	assign s_axis_tready = !(at_last_byte && (bank_left_q != '0));
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign frame_good    = in_xfer && at_last_byte &&
		(sreg_q[SREG_LEN-1] == TAIL_B0) && (s_axis_tdata == TAIL_B1);

	// Output side: refill the result register whenever it empties or is taken.
	assign out_free = !out_valid_q || m_axis_tready;
	assign bank_pop = out_free && (bank_left_q != '0);

	// Slot zero of the bank is the next result; words are little-endian.
	assign raw_x = {bank_q[1], bank_q[0]};
	assign raw_y = {bank_q[3], bank_q[2]};
	assign raw_s = {bank_q[5], bank_q[4]};
	assign raw_r = {bank_q[7], bank_q[6]};
	assign slot_nonzero = |{raw_x, raw_y, raw_s, raw_r};
	assign idx_ext = {2'b00, slot_idx_q};

	// Byte position, bank occupancy, frame count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			bank_left_q <= '0;
			slot_idx_q  <= '0;
			frame_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (in_header) begin
					if (s_axis_tdata == sync_byte(pos_q[1:0])) begin
						pos_q <= pos_q + POS_W'(1);
					end else if (s_axis_tdata == SYNC_B0) begin
						pos_q <= POS_W'(1);
					end else begin
						pos_q <= '0;
					end
				end else if (at_last_byte) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end

			if (frame_good) begin
				frame_cnt_q <= frame_cnt_q + FCOUNT_W'(1);
				bank_left_q <= CNT_W'(TARGET_SLOTS);
				slot_idx_q  <= '0;
			end else if (bank_pop) begin
				bank_left_q <= bank_left_q - CNT_W'(1);
				slot_idx_q  <= slot_idx_q + IDX_W'(1);
			end

			if (bank_pop) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload shift line, slot bank and result register.
	always_ff @(posedge clk) begin
		if (in_xfer && !in_header) begin
			for (int i = 0; i < SREG_LEN - 1; i++) begin
				sreg_q[i] <= sreg_q[i+1];
			end
			sreg_q[SREG_LEN-1] <= s_axis_tdata;
		end

		if (frame_good) begin
			for (int i = 0; i < PAY_BYTES; i++) begin
				bank_q[i] <= sreg_q[i];
			end
			bank_fnum_q <= frame_cnt_q + FCOUNT_W'(1);
		end else if (bank_pop) begin
			for (int i = 0; i < PAY_BYTES - SLOT_LEN; i++) begin
				bank_q[i] <= bank_q[i+SLOT_LEN];
			end
		end

		if (bank_pop) begin
			out_data_q <= {bank_fnum_q, raw_r, sm_decode(raw_s), sm_decode(raw_y),
				sm_decode(raw_x)};
			out_user_q <= {slot_nonzero, idx_ext[1:0]};
			out_last_q <= bank_left_q == CNT_W'(1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	// Checks on the bank and input hold-off.
	`RTFD_ASSERT(a_stall_only_when_busy, clk, arst_n, !s_axis_tready |-> (bank_left_q != '0))
	`RTFD_NEVER(a_bank_bound, clk, arst_n, bank_left_q > CNT_W'(TARGET_SLOTS))
	`RTFD_ASSERT(a_good_frame_fills_bank, clk, arst_n,
		frame_good |=> (bank_left_q == CNT_W'(TARGET_SLOTS)))
	`RTFD_ASSERT(a_pos_in_range, clk, arst_n, pos_q < POS_W'(FRAME_LEN))

endmodule

`default_nettype wire
